@@ rtl/symbol_table_define_lookup_unit_defines.svh @@
// Assertion macros shared by the symbol table RTL.
`ifndef SYMBOL_TABLE_DEFINE_LOOKUP_UNIT_DEFINES_SVH
`define SYMBOL_TABLE_DEFINE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STDL_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symbol table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define STDL_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symbol table: next-cycle check failed");

`endif

@@ rtl/stdl_pkg.sv @@
`default_nettype none

package stdl_pkg;

  localparam int CMD_W    = 2;
  localparam int NAME_W   = 64;
  localparam int LEN_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int KIND_W   = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;

  // Bytes of a name that are kept in the key.
  localparam int KEY_BYTES = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH_IDENT = 2'd0,
    CMD_SEARCH_LABEL = 2'd1,
    CMD_DEFINE_IDENT = 2'd2,
    CMD_DEFINE_LABEL = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_REDEFINED = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the incoming word
    logic clear;      // restart the table scan
    logic step;       // advance the table scan by one entry
    logic tbl_label;  // scan works on the label table
    logic finish;     // decide, write the entry, load the result register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic search_only;  // held command is a search of the identifier table
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/stdl_if.sv @@
`default_nettype none

interface stdl_req_if;
  logic                          valid;
  logic                          ready;
  logic [stdl_pkg::CMD_W-1:0]    cmd;
  logic [stdl_pkg::NAME_W-1:0]   name_chars;
  logic [stdl_pkg::LEN_W-1:0]    name_len;
  logic [stdl_pkg::VALUE_W-1:0]  value;
  logic [stdl_pkg::KIND_W-1:0]   kind;

  modport source (output valid, cmd, name_chars, name_len, value, kind, input ready);
  modport sink (input valid, cmd, name_chars, name_len, value, kind, output ready);
endinterface

interface stdl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [stdl_pkg::STATUS_W-1:0] status;
  logic [stdl_pkg::INDEX_W-1:0]  index;

  modport source (output valid, status, index, input ready);
  modport sink (input valid, status, index, output ready);
endinterface

`default_nettype wire

@@ rtl/stdl_ram.sv @@
`default_nettype none

module stdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/stdl_ctrl.sv @@
`default_nettype none

`include "symbol_table_define_lookup_unit_defines.svh"

module stdl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire stdl_pkg::cmd_t      req_cmd,
  output logic                     req_ready,
  input  wire stdl_pkg::dp_stat_t  stat,
  output stdl_pkg::ctrl_cmd_t      ctl
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN_IDENT,
    SCAN_LABEL,
    FINISH
  } state_t;

  state_t state;

  assign req_ready = (state == IDLE);

  always_comb begin
    ctl = '0;
    unique case (state)
      IDLE: begin
        ctl.load  = req_valid;
        ctl.clear = req_valid;
      end
      SCAN_IDENT: begin
        if (!stat.scan_done) begin
          ctl.step = 1'b1;
        end else if (!stat.search_only && !stat.hit) begin
          // A define found no duplicate among identifiers: labels are next.
          ctl.clear = 1'b1;
        end
      end
      SCAN_LABEL: begin
        ctl.tbl_label = 1'b1;
        ctl.step      = !stat.scan_done;
      end
      FINISH: begin
        ctl.finish = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            state <= (req_cmd == stdl_pkg::CMD_SEARCH_LABEL) ? SCAN_LABEL : SCAN_IDENT;
          end
        end
        SCAN_IDENT: begin
          if (stat.scan_done) begin
            state <= (stat.search_only || stat.hit) ? FINISH : SCAN_LABEL;
          end
        end
        SCAN_LABEL: begin
          if (stat.scan_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `STDL_ASSERT_NEXT(a_finish_to_idle, clk, rst, ctl.finish, state == IDLE)
  `STDL_ASSERT_NEXT(a_load_to_scan, clk, rst, ctl.load, state == SCAN_IDENT || state == SCAN_LABEL)
  `STDL_ASSERT_NEXT(a_rescan_is_label, clk, rst, ctl.clear && !ctl.load, state == SCAN_LABEL)

endmodule

`default_nettype wire

@@ rtl/stdl_dp.sv @@
`default_nettype none

`include "symbol_table_define_lookup_unit_defines.svh"

module stdl_dp #(
  parameter int MAX_IDENTS     = 64,
  parameter int MAX_LABELS     = 64,
  parameter int MAX_NAME_CHARS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire stdl_pkg::cmd_t                     req_cmd,
  input  wire logic [stdl_pkg::NAME_W-1:0]        req_name_chars,
  input  wire logic [stdl_pkg::LEN_W-1:0]         req_name_len,
  input  wire logic [stdl_pkg::VALUE_W-1:0]       req_value,
  input  wire logic [stdl_pkg::KIND_W-1:0]        req_kind,
  input  wire stdl_pkg::ctrl_cmd_t                ctl,
  output stdl_pkg::dp_stat_t                      stat,
  input  wire logic                               rsp_ready,
  output logic                                    rsp_valid,
  output logic      [stdl_pkg::STATUS_W-1:0]      rsp_status,
  output logic      [stdl_pkg::INDEX_W-1:0]       rsp_index
);

  localparam int CAP_MAX = (MAX_IDENTS > MAX_LABELS) ? MAX_IDENTS : MAX_LABELS;
  localparam int PW      = $clog2(CAP_MAX + 1);
  localparam int IAW     = (MAX_IDENTS > 1) ? $clog2(MAX_IDENTS) : 1;
  localparam int LAW     = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int NW      = stdl_pkg::NAME_W;
  localparam int IRW     = NW + stdl_pkg::VALUE_W + stdl_pkg::KIND_W;
  localparam int LRW     = NW + stdl_pkg::VALUE_W;

  // Held word.
  stdl_pkg::cmd_t                  cmd_q;
  logic [NW-1:0]                   key_q;
  logic [stdl_pkg::LEN_W-1:0]      len_q;
  logic [stdl_pkg::VALUE_W-1:0]    value_q;
  logic [stdl_pkg::KIND_W-1:0]     kind_q;
  logic                            long_q;

  // Table state and scan.
  logic [PW-1:0] icount;
  logic [PW-1:0] lcount;
  logic [PW-1:0] ptr;
  logic [PW-1:0] pend_idx;
  logic          pend;
  logic          hit;
  logic [PW-1:0] hit_idx;

  logic [stdl_pkg::STATUS_W-1:0] status_q;
  logic [stdl_pkg::INDEX_W-1:0]  index_q;

  logic [NW-1:0]   key_in;
  logic [IRW-1:0]  ident_rd;
  logic [LRW-1:0]  label_rd;
  logic [NW-1:0]   rd_name;
  logic [PW-1:0]   scan_cnt;
  logic            issue;
  logic            match;
  logic            is_label;
  logic            is_define;
  logic [PW-1:0]   def_cnt;
  logic            full;
  logic            too_long;
  logic            do_write;
  logic            wr_ident;
  logic            wr_label;
  stdl_pkg::status_t             res_status;
  logic [stdl_pkg::INDEX_W-1:0]  res_index;

  // Bytes at or beyond the length are cleared before compare or store.
  always_comb begin
    for (int b = 0; b < stdl_pkg::KEY_BYTES; b++) begin
      key_in[b*8 +: 8] = (stdl_pkg::LEN_W'(b) < req_name_len) ? req_name_chars[b*8 +: 8] : 8'h00;
    end
  end

  assign scan_cnt = ctl.tbl_label ? lcount : icount;
  assign issue    = ctl.step && (ptr < scan_cnt);
  assign rd_name  = ctl.tbl_label ? label_rd[NW-1:0] : ident_rd[NW-1:0];
  assign match    = pend && !hit && !long_q && (rd_name == key_q);

  assign is_label  = (cmd_q == stdl_pkg::CMD_SEARCH_LABEL) || (cmd_q == stdl_pkg::CMD_DEFINE_LABEL);
  assign is_define = (cmd_q == stdl_pkg::CMD_DEFINE_IDENT) || (cmd_q == stdl_pkg::CMD_DEFINE_LABEL);
  assign def_cnt   = is_label ? lcount : icount;
  assign full      = is_label ? (lcount >= PW'(MAX_LABELS)) : (icount >= PW'(MAX_IDENTS));
  assign too_long  = len_q > stdl_pkg::LEN_W'(MAX_NAME_CHARS);

  always_comb begin
    res_status = stdl_pkg::ST_OK;
    res_index  = '0;
    do_write   = 1'b0;
    if (!is_define) begin
      if (hit) begin
        res_index = stdl_pkg::INDEX_W'(hit_idx);
      end else begin
        res_status = stdl_pkg::ST_NOT_FOUND;
      end
    end else if (hit) begin
      res_status = stdl_pkg::ST_REDEFINED;
    end else if (full) begin
      res_status = stdl_pkg::ST_FULL;
    end else if (too_long) begin
      res_status = stdl_pkg::ST_TOO_LONG;
    end else begin
      do_write  = 1'b1;
      res_index = stdl_pkg::INDEX_W'(def_cnt);
    end
  end

  assign wr_ident = ctl.finish && do_write && !is_label;
  assign wr_label = ctl.finish && do_write && is_label;

  stdl_ram #(.WIDTH(IRW), .DEPTH(MAX_IDENTS)) u_ident_ram (
    .clk     (clk),
    .wr_en   (wr_ident),
    .wr_addr (icount[IAW-1:0]),
    .wr_data ({kind_q, value_q, key_q}),
    .rd_addr (ptr[IAW-1:0]),
    .rd_data (ident_rd)
  );

  stdl_ram #(.WIDTH(LRW), .DEPTH(MAX_LABELS)) u_label_ram (
    .clk     (clk),
    .wr_en   (wr_label),
    .wr_addr (lcount[LAW-1:0]),
    .wr_data ({value_q, key_q}),
    .rd_addr (ptr[LAW-1:0]),
    .rd_data (label_rd)
  );

  always_comb begin
    stat.scan_done   = hit || long_q || (!pend && (ptr >= scan_cnt));
    stat.hit         = hit;
    stat.search_only = (cmd_q == stdl_pkg::CMD_SEARCH_IDENT);
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      icount    <= '0;
      lcount    <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        ptr  <= '0;
        pend <= 1'b0;
        hit  <= 1'b0;
      end else if (ctl.step) begin
        pend <= issue;
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (wr_ident) begin
        icount <= icount + 1'b1;
      end
      if (wr_label) begin
        lcount <= lcount + 1'b1;
      end
      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= req_cmd;
      key_q   <= key_in;
      len_q   <= req_name_len;
      value_q <= req_value;
      kind_q  <= req_kind;
      long_q  <= req_name_len > stdl_pkg::LEN_W'(stdl_pkg::KEY_BYTES);
    end
    if (ctl.step) begin
      pend_idx <= ptr;
    end
    if (ctl.step && match) begin
      hit_idx <= pend_idx;
    end
    if (ctl.finish) begin
      status_q <= res_status;
      index_q  <= res_index;
    end
  end

  assign rsp_status = status_q;
  assign rsp_index  = index_q;

  `STDL_ASSERT_IMPL(a_ident_count_bound, clk, rst, 1'b1, icount <= PW'(MAX_IDENTS))
  `STDL_ASSERT_IMPL(a_label_count_bound, clk, rst, 1'b1, lcount <= PW'(MAX_LABELS))
  `STDL_ASSERT_IMPL(a_long_never_hits, clk, rst, long_q && !ctl.load, !hit)

endmodule

`default_nettype wire

@@ rtl/symbol_table_define_lookup_unit.sv @@
// Channel | Dir | Word contents
// req     | in  | cmd, name_chars, name_len, value, kind
// rsp     | out | status, index
//
// One request word is worked at a time. A search scans its own table, one
// entry per cycle through the registered read port of that table's name RAM.
// A define scans the identifier table and, if no duplicate turns up there,
// then the label table before its result is decided.
// Reset clears both entry counts and the controller; RAM contents need no clear.
// A response that is not taken holds in the result register while the next
// request is accepted and scanned; only its final decision waits for the slot.
`default_nettype none

module symbol_table_define_lookup_unit #(
  parameter int MAX_IDENTS     = 64,
  parameter int MAX_LABELS     = 64,
  parameter int MAX_NAME_CHARS = 8
) (
  input wire logic    clk,
  input wire logic    rst,
  stdl_req_if.sink    req,
  stdl_rsp_if.source  rsp
);

  // Command and status between the controller and the datapath.
  stdl_pkg::ctrl_cmd_t ctl;
  stdl_pkg::dp_stat_t  stat;

  // The controller only needs to know, at acceptance, whether the request
  // goes straight to the label table.
  stdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (stdl_pkg::cmd_t'(req.cmd)),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the request, both tables, the scan pointer and the
  // result register that drives the response channel.
  stdl_dp #(
    .MAX_IDENTS     (MAX_IDENTS),
    .MAX_LABELS     (MAX_LABELS),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_cmd        (stdl_pkg::cmd_t'(req.cmd)),
    .req_name_chars (req.name_chars),
    .req_name_len   (req.name_len),
    .req_value      (req.value),
    .req_kind       (req.kind),
    .ctl            (ctl),
    .stat           (stat),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_status     (rsp.status),
    .rsp_index      (rsp.index)
  );

endmodule

`default_nettype wire
